// File: sv/dtm_pkg.sv
package dtm_pkg;

  // Function tables hold entries 0 to TAB_N.
  localparam int TAB_N      = 256;
  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 16;

  typedef logic [31:0] tab_t [0:TAB_N];

  typedef enum logic [1:0] {
    MODE_TANH = 2'd0,
    MODE_CLIP = 2'd1,
    MODE_FUZZ = 2'd2,
    MODE_FOLD = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_DRIVE = 3'd1,
    REG_NORM  = 3'd2,
    REG_TONE  = 3'd3,
    REG_MIX   = 3'd4,
    REG_LEVEL = 3'd5,
    REG_COEFF = 3'd6
  } reg_idx_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] drive;
    logic [14:0] norm;
    logic [15:0] tone;
    logic [15:0] mix;
    logic [15:0] level;
    logic [15:0] coeff;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:  MODE_TANH,
    drive: 16'd8192,
    norm:  15'd16395,
    tone:  16'd32768,
    mix:   16'd32768,
    level: 16'd32768,
    coeff: 16'd21286
  };

  typedef enum logic [3:0] {
    S_IDLE, S_DRV, S_SHP, S_INT, S_INTD, S_NRM, S_NRMD,
    S_F1, S_F1D, S_F2, S_F2D, S_WET, S_MIXD, S_LVL, S_OUT
  } state_e;

  // Unsigned restoring long division, used only while building the tables.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Builds the exp(-k/16) or tanh(k/32) table at elaboration, scaled by 2^frac.
  // Both derive from a Q.32 exponential chain so the two tables stay consistent.
  function automatic tab_t build_tab(input int frac, input bit is_tanh);
    logic [63:0] term;
    logic [63:0] q;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    tab_t        t;
    term = 64'h1_0000_0000;
    q    = 64'h1_0000_0000;
    e    = 64'h1_0000_0000;
    for (int n = 1; n <= 8; n++) begin
      term = div_u64(term, 64'(16 * n));
      if (n[0]) begin
        q = q - term;
      end else begin
        q = q + term;
      end
    end
    for (int k = 0; k <= TAB_N; k++) begin
      if (k > 0) begin
        e = (e * q + 64'h8000_0000) >> 32;
      end
      if (is_tanh) begin
        den  = 64'h1_0000_0000 + e;
        num  = ((64'h1_0000_0000 - e) << frac) + (den >> 1);
        t[k] = 32'(div_u64(num, den));
      end else begin
        t[k] = 32'((e + (64'd1 << (31 - frac))) >> (32 - frac));
      end
    end
    return t;
  endfunction

endpackage

// File: sv/dtm_if.sv
// Sample input channel.
interface dtm_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          chan;
  modport source (output valid, output in_sample, output chan, input ready);
  modport sink (input valid, input in_sample, input chan, output ready);
endinterface

// Sample output channel.
interface dtm_out_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_chan;
  modport source (output valid, output out_sample, output out_chan, input ready);
  modport sink (input valid, input out_sample, input out_chan, output ready);
endinterface

// Register write channel.
interface dtm_cfg_if import dtm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [REG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/waveshaper_distortion_tone_mix_unit.sv
// Channel  Dir  Contents                         Transfer
// cfg_i    in   index, data                      valid && ready (ready always high)
// in_i     in   in_sample, chan                  valid && ready
// out_o    out  out_sample, out_chan             valid && ready
//
// A sequencer sharing one multiplier runs each sample; hard clip, wavefolder and
// zero drive skip interpolation and normalization, fuzz skips normalization.
// A two-word queue holds samples while the sequencer works, and an output
// register lets the next sample run while a result waits to be taken.
// Reset restores the register defaults and clears every channel's lowpass state at once.
module waveshaper_distortion_tone_mix_unit import dtm_pkg::*; #(
  parameter int CHANNELS = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtm_cfg_if.sink   cfg_i,
  dtm_in_if.sink    in_i,
  dtm_out_if.source out_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t                          cfg_q;
  logic                          q_valid, q_chan, pop;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic [CH_W-1:0]               q_idx;

  assign cfg_i.ready = 1'b1;

  // Register file; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_MODE:  cfg_q.mode  <= mode_e'(cfg_i.data[1:0]);
        REG_DRIVE: cfg_q.drive <= cfg_i.data;
        REG_NORM:  cfg_q.norm  <= cfg_i.data[14:0];
        REG_TONE:  cfg_q.tone  <= cfg_i.data;
        REG_MIX:   cfg_q.mix   <= cfg_i.data;
        REG_LEVEL: cfg_q.level <= cfg_i.data;
        REG_COEFF: cfg_q.coeff <= cfg_i.data;
        default:   ;
      endcase
    end
  end

  dtm_front #(
    .CHANNELS(CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_i),
    .pop_i(pop),
    .q_valid_o(q_valid),
    .q_sample_o(q_sample),
    .q_chan_o(q_chan),
    .q_idx_o(q_idx)
  );

  dtm_back #(
    .CHANNELS(CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_q),
    .q_valid_i(q_valid),
    .q_sample_i(q_sample),
    .q_chan_i(q_chan),
    .q_idx_i(q_idx),
    .pop_o(pop),
    .out_o(out_o)
  );

endmodule

// File: sv/dtm_front.sv
module dtm_front #(
  parameter int CHANNELS = 2,
  parameter int SAMPLE_BITS = 24,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dtm_in_if.sink                        in_i,
  input  logic                          pop_i,
  output logic                          q_valid_o,
  output logic signed [SAMPLE_BITS-1:0] q_sample_o,
  output logic                          q_chan_o,
  output logic [CH_W-1:0]               q_idx_o
);

  localparam int DEPTH = 2;

  logic signed [SAMPLE_BITS-1:0] x_q [DEPTH];
  logic                          c_q [DEPTH];
  logic [CH_W-1:0]               i_q [DEPTH];
  logic                          wr_q, rd_q;
  logic [1:0]                    cnt_q;
  logic                          push, pop;
  logic [CH_W-1:0]               idx;

  // A channel number past the last filter maps onto the last one.
  always_comb begin
    if (32'(in_i.chan) < CHANNELS) begin
      idx = CH_W'(in_i.chan);
    end else begin
      idx = CH_W'(CHANNELS - 1);
    end
  end

  assign in_i.ready = (cnt_q != 2'(DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != 2'd0);

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      x_q[wr_q] <= in_i.in_sample;
      c_q[wr_q] <= in_i.chan;
      i_q[wr_q] <= idx;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_sample_o = x_q[rd_q];
  assign q_chan_o   = c_q[rd_q];
  assign q_idx_o    = i_q[rd_q];

endmodule

// File: sv/dtm_back.sv
module dtm_back import dtm_pkg::*; #(
  parameter int CHANNELS = 2,
  parameter int SAMPLE_BITS = 24,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          q_valid_i,
  input  logic signed [SAMPLE_BITS-1:0] q_sample_i,
  input  logic                          q_chan_i,
  input  logic [CH_W-1:0]               q_idx_i,
  output logic                          pop_o,
  dtm_out_if.source                     out_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int FRAC  = SB - 1;
  localparam int ST_W  = SB + 4;
  localparam int W_W   = SB + 1;
  localparam int S_W   = SB + 6;
  localparam int D_W   = SB + 6;
  localparam int BV_W  = SB + 8;
  localparam int A_W   = SB + 11;
  localparam int B_W   = (SB - 4 > 17) ? SB - 4 : 17;
  localparam int P_W   = A_W + B_W;
  localparam int BT    = FRAC - 5;
  localparam int BE    = FRAC - 4;
  localparam int FB    = BE;

  localparam logic signed [W_W-1:0]  ONE_W     = {2'b01, {FRAC{1'b0}}};
  localparam logic signed [W_W-1:0]  NEG_ONE_W = {2'b11, {FRAC{1'b0}}};
  localparam logic signed [W_W:0]    TWO_W     = {3'b010, {FRAC{1'b0}}};
  localparam logic signed [P_W-1:0]  O_MAX     = P_W'({1'b0, {FRAC{1'b1}}});
  localparam logic signed [P_W-1:0]  O_MIN     = P_W'($signed({1'b1, {FRAC{1'b0}}}));
  localparam tab_t TANH_TAB = build_tab(FRAC, 1'b1);
  localparam tab_t EXP_TAB  = build_tab(FRAC, 1'b0);

  state_e state_q, state_d;

  logic signed [SB-1:0]   x_q;
  logic                   chan_q;
  logic [CH_W-1:0]        idx_q;
  logic                   neg_q;
  logic                   dsc_q;
  logic [SB-1:0]          a_q, d_q, t_q;
  logic [FB-1:0]          f_q;
  logic signed [W_W-1:0]  w_q;
  logic signed [ST_W-1:0] stn_q;
  logic signed [BV_W-1:0] b_q;
  logic signed [P_W-1:0]  acc_q, p_q;
  logic signed [A_W-1:0]  m_q;
  logic signed [ST_W-1:0] st_q [CHANNELS];
  logic                   out_valid_q;
  logic signed [SB-1:0]   out_sample_q;
  logic                   out_chan_q;

  logic signed [A_W-1:0]  mul_a;
  logic signed [B_W-1:0]  mul_b;
  logic signed [P_W-1:0]  prod;
  logic                   out_load;
  logic                   use_exp;

  // Shaping signals.
  logic signed [S_W-1:0]  s;
  logic [S_W-1:0]         mag, idx_full;
  logic                   clamp;
  logic [8:0]             ia, ic;
  logic [FB-1:0]          fr;
  logic [SB-1:0]          ta, tc;
  logic signed [W_W-1:0]  w_clip, w_fold;
  logic signed [S_W-1:0]  fsum;
  logic signed [W_W:0]    g, ag;

  // Interpolation and filter signals.
  logic [SB-1:0]          qv, val;
  logic signed [W_W-1:0]  w_fuzz, w_tanh;
  logic [P_W-1:0]         rsum;
  logic [SB-1:0]          rr;
  logic signed [W_W-1:0]  rc;
  logic signed [SB+4:0]   w16;
  logic signed [ST_W-1:0] st_sel, stn;
  logic signed [D_W-1:0]  diff1, diff2;
  logic signed [BV_W-1:0] bsum;
  logic signed [P_W-1:0]  msum, o_full;
  logic signed [16:0]     dry_gain;

  assign use_exp = (cfg_i.mode == MODE_FUZZ);

  // Table lookup from the driven sample.
  always_comb begin
    s        = $signed(p_q[11 +: S_W]);
    mag      = s[S_W-1] ? (~s + 1'b1) : s;
    idx_full = use_exp ? (mag >> BE) : (mag >> BT);
    clamp    = (idx_full >= S_W'(TAB_N));
    ia       = clamp ? 9'(TAB_N) : idx_full[8:0];
    ic       = clamp ? 9'(TAB_N) : ia + 9'd1;
    if (clamp) begin
      fr = '0;
    end else if (use_exp) begin
      fr = mag[BE-1:0];
    end else begin
      fr = FB'(mag[BT-1:0]);
    end
    ta = use_exp ? EXP_TAB[ia][SB-1:0] : TANH_TAB[ia][SB-1:0];
    tc = use_exp ? EXP_TAB[ic][SB-1:0] : TANH_TAB[ic][SB-1:0];
  end

  // Hard clip and triangle fold.
  always_comb begin
    if (s > S_W'(ONE_W)) begin
      w_clip = ONE_W;
    end else if (s < S_W'(NEG_ONE_W)) begin
      w_clip = NEG_ONE_W;
    end else begin
      w_clip = W_W'(s);
    end
    fsum   = s + S_W'(ONE_W);
    g      = $signed({1'b0, fsum[FRAC+1:0]}) - TWO_W;
    ag     = g[W_W] ? -g : g;
    w_fold = W_W'((W_W+1)'(ONE_W) - ag);
  end

  // Interpolation result, normalization and filter arithmetic.
  always_comb begin
    qv       = use_exp ? SB'(p_q >> BE) : SB'(p_q >> BT);
    val      = dsc_q ? a_q - qv : a_q + qv;
    w_fuzz   = neg_q ? -(ONE_W - W_W'(val)) : (ONE_W - W_W'(val));
    rsum     = p_q + P_W'(8192);
    rr       = rsum[14 +: SB];
    rc       = (W_W'(rr) > ONE_W) ? ONE_W : W_W'(rr);
    w_tanh   = neg_q ? -rc : rc;
    w16      = {w_q, 4'b0000};
    st_sel   = st_q[idx_q];
    diff1    = D_W'(w16) - D_W'(st_sel);
    stn      = st_sel + $signed(p_q[16 +: ST_W]);
    diff2    = D_W'(w16) - D_W'(stn_q);
    bsum     = BV_W'(stn_q) + $signed(p_q[15 +: BV_W]);
    msum     = acc_q + p_q;
    o_full   = p_q >>> 19;
    dry_gain = $signed(17'd32768) - $signed({1'b0, cfg_i.mix});
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (q_valid_i) state_d = S_DRV;
      S_DRV:  state_d = S_SHP;
      S_SHP: begin
        unique case (cfg_i.mode)
          MODE_TANH: state_d = (cfg_i.drive == '0) ? S_F1 : S_INT;
          MODE_FUZZ: state_d = S_INT;
          default:   state_d = S_F1;
        endcase
      end
      S_INT:  state_d = S_INTD;
      S_INTD: state_d = use_exp ? S_F1 : S_NRM;
      S_NRM:  state_d = S_NRMD;
      S_NRMD: state_d = S_F1;
      S_F1:   state_d = S_F1D;
      S_F1D:  state_d = S_F2;
      S_F2:   state_d = S_F2D;
      S_F2D:  state_d = S_WET;
      S_WET:  state_d = S_MIXD;
      S_MIXD: state_d = S_LVL;
      S_LVL:  state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Multiplier operands and strobes.
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q)
      S_IDLE: pop_o = q_valid_i;
      S_DRV: begin
        mul_a = A_W'(x_q);
        mul_b = B_W'($signed({1'b0, cfg_i.drive}));
      end
      S_INT: begin
        mul_a = A_W'($signed({1'b0, d_q}));
        mul_b = B_W'($signed({1'b0, f_q}));
      end
      S_NRM: begin
        mul_a = A_W'($signed({1'b0, t_q}));
        mul_b = B_W'($signed({1'b0, cfg_i.norm}));
      end
      S_F1: begin
        mul_a = A_W'(diff1);
        mul_b = B_W'($signed({1'b0, cfg_i.coeff}));
      end
      S_F2: begin
        mul_a = A_W'(diff2);
        mul_b = B_W'($signed({1'b0, cfg_i.tone}));
      end
      S_F2D: begin
        mul_a = A_W'($signed({x_q, 4'b0000}));
        mul_b = B_W'(dry_gain);
      end
      S_WET: begin
        mul_a = A_W'(b_q);
        mul_b = B_W'($signed({1'b0, cfg_i.mix}));
      end
      S_LVL: begin
        mul_a = m_q;
        mul_b = B_W'($signed({1'b0, cfg_i.level}));
      end
      S_OUT: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Datapath registers; the level product holds while a result waits.
  always_ff @(posedge clk_i) begin
    if (state_q != S_OUT) begin
      p_q <= prod;
    end
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          x_q    <= q_sample_i;
          chan_q <= q_chan_i;
          idx_q  <= q_idx_i;
        end
      end
      S_SHP: begin
        a_q   <= ta;
        d_q   <= (ta >= tc) ? ta - tc : tc - ta;
        dsc_q <= (ta >= tc);
        f_q   <= fr;
        neg_q <= use_exp ? x_q[SB-1] : s[S_W-1];
        case (cfg_i.mode)
          MODE_TANH: w_q <= W_W'(x_q);
          MODE_CLIP: w_q <= w_clip;
          MODE_FOLD: w_q <= w_fold;
          default:   ;
        endcase
      end
      S_INTD: begin
        if (use_exp) begin
          w_q <= w_fuzz;
        end else begin
          t_q <= val;
        end
      end
      S_NRMD: w_q <= w_tanh;
      S_F1D:  stn_q <= stn;
      S_F2D:  b_q <= bsum;
      S_WET:  acc_q <= p_q;
      S_MIXD: m_q <= msum[15 +: A_W];
      default: ;
    endcase
  end

  // Per-channel lowpass state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) st_q[c] <= '0;
    end else if (state_q == S_F1D) begin
      st_q[idx_q] <= stn;
    end
  end

  // Output register with saturation.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_chan_q <= chan_q;
      if (o_full > O_MAX) begin
        out_sample_q <= SB'(O_MAX);
      end else if (o_full < O_MIN) begin
        out_sample_q <= SB'(O_MIN);
      end else begin
        out_sample_q <= SB'(o_full);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_sample_q;
  assign out_o.out_chan   = out_chan_q;

  // The shaped word entering the filter never leaves the unit range.
  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_F1) |-> (w_q <= ONE_W && w_q >= NEG_ONE_W))
    else $error("shaped word out of range");

  // A word taken from the queue starts the drive multiply next.
  a_pop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == S_DRV))
    else $error("pop did not start an item");

  // A finished word lands in the output register and the sequencer goes idle.
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == S_IDLE))
    else $error("output load did not complete the item");

endmodule
